@@ src/sm83_alu_pkg.sv @@
package sm83_alu_pkg;

	localparam int unsigned DataW = 8;
	localparam int unsigned FlagW = 4;
	localparam int unsigned OpW   = 5;
	localparam int unsigned IdxW  = 3;

	localparam int unsigned FlagZ = 3;
	localparam int unsigned FlagN = 2;
	localparam int unsigned FlagH = 1;
	localparam int unsigned FlagC = 0;

	localparam logic [DataW-1:0] DaaHighLimit = 8'd153;
	localparam logic [DataW-1:0] DaaHighAdj   = 8'd96;
	localparam logic [DataW-1:0] DaaLowAdj    = 8'd6;
	localparam logic [3:0]       DaaLowLimit  = 4'd9;

	typedef enum logic [OpW-1:0] {
		OP_ADD  = 5'd0,
		OP_ADC  = 5'd1,
		OP_SUB  = 5'd2,
		OP_SBC  = 5'd3,
		OP_AND  = 5'd4,
		OP_XOR  = 5'd5,
		OP_OR   = 5'd6,
		OP_CP   = 5'd7,
		OP_INC  = 5'd8,
		OP_DEC  = 5'd9,
		OP_DAA  = 5'd10,
		OP_CPL  = 5'd11,
		OP_SCF  = 5'd12,
		OP_CCF  = 5'd13,
		OP_RLC  = 5'd14,
		OP_RRC  = 5'd15,
		OP_RL   = 5'd16,
		OP_RR   = 5'd17,
		OP_SLA  = 5'd18,
		OP_SRA  = 5'd19,
		OP_SWAP = 5'd20,
		OP_SRL  = 5'd21,
		OP_BIT  = 5'd22,
		OP_RES  = 5'd23,
		OP_SET  = 5'd24
	} op_t;

	typedef struct packed {
		logic [OpW-1:0]   req_type;
		logic [DataW-1:0] acc_value;
		logic [DataW-1:0] operand_value;
		logic [FlagW-1:0] flags_in;
		logic [IdxW-1:0]  bit_index;
		logic             accumulator_form;
	} req_t;

	typedef struct packed {
		logic [DataW-1:0] result_value;
		logic [FlagW-1:0] flags_out;
		logic             write_result;
	} rsp_t;

endpackage

@@ src/sm83_stream_if.sv @@
interface sm83_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (
		output valid,
		output payload,
		input  ready
	);

	modport sink (
		input  valid,
		input  payload,
		output ready
	);
endinterface

@@ src/sm83_alu_core.sv @@
module sm83_alu_core (
	input  sm83_alu_pkg::req_t req,
	output sm83_alu_pkg::rsp_t rsp
);
	import sm83_alu_pkg::*;

	logic [DataW-1:0] a, b, r, adj, bit_mask;
	logic             fz, fn, fh, fc;
	logic             z, n, h, c, wr;
	logic             cin, rot_op, adj_lo, adj_hi;
	logic [DataW:0]   sum9, diff9;
	logic [4:0]       hsum5, hdiff5;

	assign a        = req.acc_value;
	assign b        = req.operand_value;
	assign fz       = req.flags_in[FlagZ];
	assign fn       = req.flags_in[FlagN];
	assign fh       = req.flags_in[FlagH];
	assign fc       = req.flags_in[FlagC];
	assign bit_mask = DataW'(1) << req.bit_index;

	// carry in only on the with-carry forms
	assign cin    = ((req.req_type == OP_ADC) || (req.req_type == OP_SBC)) ? fc : 1'b0;
	assign sum9   = {1'b0, a} + {1'b0, b} + {{DataW{1'b0}}, cin};
	assign diff9  = {1'b0, a} - {1'b0, b} - {{DataW{1'b0}}, cin};
	assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
	assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};

	assign adj_lo = fh || (!fn && (a[3:0] > DaaLowLimit));
	assign adj_hi = fc || (!fn && (a > DaaHighLimit));
	assign adj    = (adj_lo ? DaaLowAdj : '0) | (adj_hi ? DaaHighAdj : '0);

	assign rot_op = (req.req_type >= OP_RLC) && (req.req_type <= OP_SRL);

	always_comb begin
		r  = '0;
		z  = fz;
		n  = fn;
		h  = fh;
		c  = fc;
		wr = 1'b1;
		unique case (req.req_type)
			OP_ADD, OP_ADC: begin
				r = sum9[DataW-1:0];
				n = 1'b0;
				h = hsum5[4];
				c = sum9[DataW];
			end
			OP_SUB, OP_SBC, OP_CP: begin
				r  = diff9[DataW-1:0];
				n  = 1'b1;
				h  = hdiff5[4];
				c  = diff9[DataW];
				wr = (req.req_type != OP_CP);
			end
			OP_AND: begin
				r = a & b;
				n = 1'b0;
				h = 1'b1;
				c = 1'b0;
			end
			OP_XOR: begin
				r = a ^ b;
				n = 1'b0;
				h = 1'b0;
				c = 1'b0;
			end
			OP_OR: begin
				r = a | b;
				n = 1'b0;
				h = 1'b0;
				c = 1'b0;
			end
			OP_INC: begin
				r = b + 8'd1;
				n = 1'b0;
				h = (b[3:0] == 4'hf);
			end
			OP_DEC: begin
				r = b - 8'd1;
				n = 1'b1;
				h = (b[3:0] == 4'h0);
			end
			OP_DAA: begin
				r = fn ? (a - adj) : (a + adj);
				h = 1'b0;
				c = adj_hi;
			end
			OP_CPL: begin
				r = ~a;
				n = 1'b1;
				h = 1'b1;
			end
			OP_SCF: begin
				n  = 1'b0;
				h  = 1'b0;
				c  = 1'b1;
				wr = 1'b0;
			end
			OP_CCF: begin
				n  = 1'b0;
				h  = 1'b0;
				c  = ~fc;
				wr = 1'b0;
			end
			OP_RLC: begin
				c = b[7];
				r = {b[6:0], b[7]};
			end
			OP_RRC: begin
				c = b[0];
				r = {b[0], b[7:1]};
			end
			OP_RL: begin
				c = b[7];
				r = {b[6:0], fc};
			end
			OP_RR: begin
				c = b[0];
				r = {fc, b[7:1]};
			end
			OP_SLA: begin
				c = b[7];
				r = {b[6:0], 1'b0};
			end
			OP_SRA: begin
				c = b[0];
				r = {b[7], b[7:1]};
			end
			OP_SWAP: begin
				c = 1'b0;
				r = {b[3:0], b[7:4]};
			end
			OP_SRL: begin
				c = b[0];
				r = {1'b0, b[7:1]};
			end
			OP_BIT: begin
				r  = b;
				z  = ~|(b & bit_mask);
				n  = 1'b0;
				h  = 1'b1;
				wr = 1'b0;
			end
			OP_RES: r = b & ~bit_mask;
			OP_SET: r = b | bit_mask;
			default: wr = 1'b0;
		endcase
		// zero flag from the result for ADD through DAA; the rotates and shifts set it below
		if ((req.req_type <= OP_DAA) && (req.req_type != OP_BIT)) begin
			z = (r == '0);
		end
		if (rot_op) begin
			n = 1'b0;
			h = 1'b0;
			z = req.accumulator_form ? 1'b0 : (r == '0);
		end
	end

	assign rsp.result_value = r;
	assign rsp.flags_out    = {z, n, h, c};
	assign rsp.write_result = wr;

endmodule

@@ src/eight_bit_cpu_alu_flags.sv @@
// channel | direction | payload
// req     | in        | req_type, acc_value, operand_value, flags_in, bit_index, accumulator_form
// rsp     | out       | result_value, flags_out, write_result
//
// one request per cycle while rsp.ready holds; rsp.valid rises when the result register loads
// path: request register, one pass of alu logic, result register
// arst_n clears both valid stages; payload registers are not reset
// a held result does not block a new request while the request stage is free
module eight_bit_cpu_alu_flags (
	input  logic          clk,
	input  logic          arst_n,
	sm83_stream_if.sink   req,
	sm83_stream_if.source rsp
);
	import sm83_alu_pkg::*;

	logic valid_s1, valid_s2;
	req_t req_s1;
	rsp_t rsp_s2;
	rsp_t alu_rsp;
	logic ready_s1, ready_s2;

	assign ready_s2  = !valid_s2 || rsp.ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign req.ready = ready_s1;

	sm83_alu_core u_core (
		.req (req_s1),
		.rsp (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= req.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && req.valid) begin
			req_s1 <= req.payload;
		end
		if (ready_s2 && valid_s1) begin
			rsp_s2 <= alu_rsp;
		end
	end

	assign rsp.valid   = valid_s2;
	assign rsp.payload = rsp_s2;

	a_req_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> valid_s1)
		else $error("accepted request did not reach the request stage");

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ready_s2) |=> (valid_s2 && (rsp_s2 == $past(alu_rsp))))
		else $error("alu result not captured in result stage");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> req.ready)
		else $error("request refused with empty result stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ready_s2) |=> (valid_s1 && $stable(req_s1)))
		else $error("request stage lost its contents while stalled");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import sm83_alu_pkg::*;

	localparam logic [OpW-1:0] OpUnusedLo = 5'd25;
	localparam logic [OpW-1:0] OpUnusedHi = 5'd31;
	localparam int RandomOps   = 1050;
	localparam int CycleLimit  = 600000;
	localparam int DrainCycles = 8;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sm83_stream_if #(.payload_t(req_t)) req_if ();
	sm83_stream_if #(.payload_t(rsp_t)) rsp_if ();

	eight_bit_cpu_alu_flags u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	req_t op_backlog[$];
	rsp_t alu_results_due[$];

	int mismatches  = 0;
	int cycle_count = 0;
	int rsp_count   = 0;
	int req_gap     = 0;
	int req_burst   = 0;
	int rsp_stall   = 0;
	int rsp_free    = 0;
	int hold_phase  = 0;

	always #4 clk = ~clk;

	function automatic rsp_t sm83_alu_eval(req_t q);
		logic [DataW-1:0] a, b, r, adj;
		logic [DataW:0]   sum, bc;
		logic [4:0]       hs, hb;
		logic             fz, fn, fh, fc, z, n, h, c, wr, cin;
		rsp_t             o;
		a = q.acc_value;
		b = q.operand_value;
		{fz, fn, fh, fc} = q.flags_in;
		z = fz;
		n = fn;
		h = fh;
		c = fc;
		wr = 1'b1;
		r = '0;
		case (q.req_type)
			OP_ADD, OP_ADC: begin
				cin = (q.req_type == OP_ADC) ? fc : 1'b0;
				sum = {1'b0, a} + {1'b0, b} + cin;
				hs = {1'b0, a[3:0]} + {1'b0, b[3:0]} + cin;
				r = sum[DataW-1:0];
				z = (r == '0);
				n = 1'b0;
				h = hs[4];
				c = sum[DataW];
			end
			OP_SUB, OP_SBC, OP_CP: begin
				cin = (q.req_type == OP_SBC) ? fc : 1'b0;
				r = a - b - cin;
				hb = {1'b0, b[3:0]} + cin;
				bc = {1'b0, b} + cin;
				z = (r == '0);
				n = 1'b1;
				h = ({1'b0, a[3:0]} < hb);
				c = ({1'b0, a} < bc);
				wr = (q.req_type != OP_CP);
			end
			OP_AND: begin
				r = a & b;
				z = (r == '0);
				n = 1'b0;
				h = 1'b1;
				c = 1'b0;
			end
			OP_XOR: begin
				r = a ^ b;
				z = (r == '0);
				n = 1'b0;
				h = 1'b0;
				c = 1'b0;
			end
			OP_OR: begin
				r = a | b;
				z = (r == '0);
				n = 1'b0;
				h = 1'b0;
				c = 1'b0;
			end
			OP_INC: begin
				r = b + 8'd1;
				z = (r == '0);
				n = 1'b0;
				h = (b[3:0] == 4'hf);
			end
			OP_DEC: begin
				r = b - 8'd1;
				z = (r == '0);
				n = 1'b1;
				h = (b[3:0] == 4'h0);
			end
			OP_DAA: begin
				adj = '0;
				c = 1'b0;
				if (fh || (!fn && a[3:0] > DaaLowLimit)) begin
					adj = DaaLowAdj;
				end
				if (fc || (!fn && a > DaaHighLimit)) begin
					adj = adj | DaaHighAdj;
					c = 1'b1;
				end
				r = fn ? (a - adj) : (a + adj);
				z = (r == '0);
				h = 1'b0;
			end
			OP_CPL: begin
				r = ~a;
				n = 1'b1;
				h = 1'b1;
			end
			OP_SCF: begin
				n = 1'b0;
				h = 1'b0;
				c = 1'b1;
				wr = 1'b0;
			end
			OP_CCF: begin
				n = 1'b0;
				h = 1'b0;
				c = ~fc;
				wr = 1'b0;
			end
			OP_RLC: begin
				c = b[7];
				r = {b[6:0], b[7]};
			end
			OP_RRC: begin
				c = b[0];
				r = {b[0], b[7:1]};
			end
			OP_RL: begin
				c = b[7];
				r = {b[6:0], fc};
			end
			OP_RR: begin
				c = b[0];
				r = {fc, b[7:1]};
			end
			OP_SLA: begin
				c = b[7];
				r = {b[6:0], 1'b0};
			end
			OP_SRA: begin
				c = b[0];
				r = {b[7], b[7:1]};
			end
			OP_SWAP: begin
				c = 1'b0;
				r = {b[3:0], b[7:4]};
			end
			OP_SRL: begin
				c = b[0];
				r = {1'b0, b[7:1]};
			end
			OP_BIT: begin
				r = b;
				z = ~b[q.bit_index];
				n = 1'b0;
				h = 1'b1;
				wr = 1'b0;
			end
			OP_RES: r = b & ~(8'd1 << q.bit_index);
			OP_SET: r = b | (8'd1 << q.bit_index);
			default: begin
				r = '0;
				wr = 1'b0;
			end
		endcase
		if ((q.req_type >= OP_RLC) && (q.req_type <= OP_SRL)) begin
			n = 1'b0;
			h = 1'b0;
			z = q.accumulator_form ? 1'b0 : (r == '0);
		end
		o.result_value = r;
		o.flags_out    = {z, n, h, c};
		o.write_result = wr;
		return o;
	endfunction

	function automatic req_t mk_req(logic [OpW-1:0] op, logic [DataW-1:0] a,
			logic [DataW-1:0] b, logic [FlagW-1:0] f, logic [IdxW-1:0] idx,
			logic accf);
		req_t q;
		q.req_type         = op;
		q.acc_value        = a;
		q.operand_value    = b;
		q.flags_in         = f;
		q.bit_index        = idx;
		q.accumulator_form = accf;
		return q;
	endfunction

	function automatic logic [DataW-1:0] rand_byte();
		logic [DataW-1:0] v;
		if ($urandom_range(0, 99) < 20) begin
			case ($urandom_range(0, 7))
				0: v = 8'h00;
				1: v = 8'hff;
				2: v = 8'h0f;
				3: v = 8'h10;
				4: v = 8'h99;
				5: v = 8'h9a;
				6: v = 8'h80;
				default: v = 8'h01;
			endcase
		end else begin
			v = DataW'($urandom_range(0, 255));
		end
		return v;
	endfunction

	function int next_req_gap();
		int roll;
		if (req_burst > 0) begin
			req_burst--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			req_burst = $urandom_range(30, 80);
			return 0;
		end
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// request side
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				alu_results_due.push_back(sm83_alu_eval(req_if.payload));
			end
			if (!req_if.valid || req_if.ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req_if.valid <= 1'b0;
				end else if (op_backlog.size() > 0) begin
					req_if.payload <= op_backlog.pop_front();
					req_if.valid <= 1'b1;
					req_gap = next_req_gap();
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk) begin
		rsp_t want;
		int   roll;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				rsp_count++;
				if (alu_results_due.size() == 0) begin
					$error("result with no request pending: %p", rsp_if.payload);
					mismatches++;
				end else begin
					want = alu_results_due.pop_front();
					if (rsp_if.payload.result_value !== want.result_value) begin
						$error("result_value expected %h actual %h",
							want.result_value, rsp_if.payload.result_value);
						mismatches++;
					end
					if (rsp_if.payload.flags_out !== want.flags_out) begin
						$error("flags_out expected %b actual %b",
							want.flags_out, rsp_if.payload.flags_out);
						mismatches++;
					end
					if (rsp_if.payload.write_result !== want.write_result) begin
						$error("write_result expected %b actual %b",
							want.write_result, rsp_if.payload.write_result);
						mismatches++;
					end
				end
			end
			if (rsp_stall > 0) begin
				rsp_stall--;
			end else if (rsp_free > 0) begin
				rsp_free--;
			end else if ((hold_phase == 0 && rsp_count >= 300) ||
					(hold_phase == 1 && rsp_count >= 800)) begin
				rsp_stall = 400;
				hold_phase++;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					rsp_free = $urandom_range(30, 100);
				end else if (roll < 25) begin
					rsp_stall = $urandom_range(1, 3);
				end else if (roll < 28) begin
					rsp_stall = $urandom_range(10, 40);
				end
			end
			rsp_if.ready <= (rsp_stall == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [OpW-1:0] op;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		rsp_if.ready   = 1'b0;

		op_backlog.push_back(mk_req(OP_ADD,  8'hff, 8'h01, 4'b0000, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_ADC,  8'h0f, 8'h00, 4'b0001, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_ADC,  8'hff, 8'hff, 4'b1111, 3'd7, 1'b1));
		op_backlog.push_back(mk_req(OP_SUB,  8'h00, 8'h01, 4'b0000, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_SBC,  8'h10, 8'h0f, 4'b0001, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_AND,  8'hf0, 8'h0f, 4'b1111, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_XOR,  8'h5a, 8'h5a, 4'b0000, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_OR,   8'h00, 8'hff, 4'b1111, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_CP,   8'h42, 8'h42, 4'b0000, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_INC,  8'h00, 8'hff, 4'b0001, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_DEC,  8'h00, 8'h00, 4'b0000, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_DEC,  8'h00, 8'h10, 4'b1001, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_DAA,  8'h9a, 8'h00, 4'b0000, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_DAA,  8'h00, 8'h00, 4'b0111, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_CPL,  8'h3c, 8'h00, 4'b1001, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_SCF,  8'hff, 8'hff, 4'b1110, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_CCF,  8'hff, 8'hff, 4'b0111, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_RLC,  8'h00, 8'h80, 4'b0000, 3'd0, 1'b1));
		op_backlog.push_back(mk_req(OP_RRC,  8'h00, 8'h01, 4'b0000, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_RL,   8'h00, 8'h80, 4'b0000, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_RR,   8'h00, 8'h01, 4'b0001, 3'd0, 1'b1));
		op_backlog.push_back(mk_req(OP_SLA,  8'h00, 8'hff, 4'b0000, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_SRA,  8'h00, 8'h81, 4'b0000, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_SWAP, 8'h00, 8'h00, 4'b0001, 3'd0, 1'b1));
		op_backlog.push_back(mk_req(OP_SRL,  8'h00, 8'h01, 4'b0000, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_BIT,  8'h00, 8'h7f, 4'b0101, 3'd7, 1'b0));
		op_backlog.push_back(mk_req(OP_RES,  8'h00, 8'hff, 4'b1010, 3'd0, 1'b0));
		op_backlog.push_back(mk_req(OP_SET,  8'h00, 8'h00, 4'b0101, 3'd7, 1'b1));
		op_backlog.push_back(mk_req(OpUnusedLo, 8'hff, 8'hff, 4'b1010, 3'd7, 1'b1));
		op_backlog.push_back(mk_req(OpUnusedHi, 8'h55, 8'haa, 4'b0101, 3'd3, 1'b0));

		for (int i = 0; i < RandomOps; i++) begin
			if ($urandom_range(0, 99) < 4) begin
				op = OpW'($urandom_range(OpUnusedLo, OpUnusedHi));
			end else begin
				op = OpW'($urandom_range(OP_ADD, OP_SET));
			end
			op_backlog.push_back(mk_req(op, rand_byte(), rand_byte(),
				FlagW'($urandom_range(0, 15)), IdxW'($urandom_range(0, 7)),
				1'($urandom_range(0, 1))));
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every request to be taken and every result to come back
		while (op_backlog.size() != 0 || req_if.valid || alu_results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
